// ----- rtl/fstlp_pkg.sv -----
`default_nettype none

package fstlp_pkg;

  localparam int unsigned DebounceLimitW = 16;
  localparam int unsigned LongPressW     = 25;
  localparam int unsigned CfgDataW       = 25;
  localparam int unsigned CfgIndexW      = 2;

  localparam logic [DebounceLimitW-1:0] DebounceLimitRst = 16'd16;
  localparam logic [LongPressW-1:0]     LongPressRst     = 25'd20000000;
  localparam logic                      InitialEffectRst = 1'b0;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_DEBOUNCE_LIMIT = 2'd0,
    CFG_LONG_PRESS     = 2'd1,
    CFG_INITIAL_EFFECT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic effect;
    logic feedback;
    logic lamp;
    logic was_released;
    logic toggle_pending;
    logic turning_on;
  } flags_t;

  typedef struct packed {
    logic effect_on;
    logic feedback_on;
    logic effect_lamp;
    logic effect_changed;
    logic feedback_changed;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/fstlp_step.sv -----
`default_nettype none

module fstlp_step #(
  parameter int unsigned HOLD_WIDTH     = 25,
  parameter int unsigned DEBOUNCE_WIDTH = 16
) (
  input  wire logic                                switch_level_i,
  input  wire logic [fstlp_pkg::DebounceLimitW-1:0] debounce_limit_i,
  input  wire logic [fstlp_pkg::LongPressW-1:0]     long_press_ticks_i,
  input  wire logic [DEBOUNCE_WIDTH-1:0]           integ_i,
  input  wire logic [HOLD_WIDTH-1:0]               hold_i,
  input  wire fstlp_pkg::flags_t                   flags_i,
  output logic      [DEBOUNCE_WIDTH-1:0]           integ_o,
  output logic      [HOLD_WIDTH-1:0]               hold_o,
  output fstlp_pkg::flags_t                        flags_o,
  output fstlp_pkg::res_t                          res_o
);
  import fstlp_pkg::*;

  localparam int unsigned LimW = (DEBOUNCE_WIDTH > DebounceLimitW) ?
                                 DEBOUNCE_WIDTH : DebounceLimitW;
  localparam int unsigned LpW  = (HOLD_WIDTH > LongPressW) ? HOLD_WIDTH : LongPressW;

  logic [LimW-1:0]           lim_ext, imax_ext;
  logic [LpW-1:0]            lp_ext, hmax_ext;
  logic [DEBOUNCE_WIDTH-1:0] limit;
  logic [HOLD_WIDTH-1:0]     longp;
  logic [HOLD_WIDTH-1:0]     hold_max;
  logic [DEBOUNCE_WIDTH-1:0] integ_n;
  logic                      eff_chg, fb_chg;
  flags_t                    nxt;

  // clip the register values to the counter ranges
  always_comb begin
    lim_ext  = LimW'(debounce_limit_i);
    imax_ext = LimW'({DEBOUNCE_WIDTH{1'b1}});
    limit    = (lim_ext > imax_ext) ? {DEBOUNCE_WIDTH{1'b1}} : DEBOUNCE_WIDTH'(lim_ext);
    lp_ext   = LpW'(long_press_ticks_i);
    hmax_ext = LpW'({HOLD_WIDTH{1'b1}});
    hold_max = {HOLD_WIDTH{1'b1}};
    longp    = (lp_ext > hmax_ext) ? hold_max : HOLD_WIDTH'(lp_ext);
  end

  always_comb begin
    integ_n = integ_i;
    if (!switch_level_i) begin
      if (integ_i != '0) integ_n = integ_i - 1'b1;
    end else if (integ_i < limit) begin
      integ_n = integ_i + 1'b1;
    end

    nxt     = flags_i;
    hold_o  = hold_i;
    integ_o = integ_n;
    eff_chg = 1'b0;
    fb_chg  = 1'b0;

    if (integ_n == '0) begin
      if (hold_i != hold_max) hold_o = hold_i + 1'b1;
      if (flags_i.effect) begin
        if (flags_i.was_released) nxt.toggle_pending = 1'b1;
        if (hold_o >= longp && !flags_i.feedback && !flags_i.turning_on) begin
          hold_o       = longp;
          nxt.lamp     = 1'b0;
          nxt.feedback = 1'b1;
          fb_chg       = 1'b1;
        end
      end else begin
        nxt.turning_on     = 1'b1;
        nxt.toggle_pending = 1'b0;
        nxt.effect         = 1'b1;
        nxt.lamp           = 1'b1;
        nxt.feedback       = 1'b0;
        eff_chg            = 1'b1;
      end
      nxt.was_released = 1'b0;
    end else if (integ_n >= limit) begin
      if (flags_i.toggle_pending && !flags_i.feedback && flags_i.effect) begin
        nxt.effect = 1'b0;
        eff_chg    = 1'b1;
      end
      nxt.lamp = nxt.effect;
      if (flags_i.feedback) begin
        nxt.feedback = 1'b0;
        fb_chg       = 1'b1;
      end
      nxt.turning_on     = 1'b0;
      nxt.toggle_pending = 1'b0;
      nxt.was_released   = 1'b1;
      hold_o             = '0;
      integ_o            = limit;
    end

    flags_o                = nxt;
    res_o.effect_on        = nxt.effect;
    res_o.feedback_on      = nxt.feedback;
    res_o.effect_lamp      = nxt.lamp;
    res_o.effect_changed   = eff_chg;
    res_o.feedback_changed = fb_chg;
  end

endmodule

`default_nettype wire

// ----- rtl/footswitch_toggle_long_press_unit.sv -----
// An accepted word goes to the input register, then to the result register as
// its result word. Throughput: one word per cycle while the result side is not
// stalled; the tick update is a single pass of the step logic between them.
// Reset (rst_ni low, async): registers return to their defaults, the counters
// clear, effect and lamp take the initial_effect default, both channels empty.
`default_nettype none

module footswitch_toggle_long_press_unit #(
  parameter int unsigned HOLD_WIDTH     = 25,
  parameter int unsigned DEBOUNCE_WIDTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [fstlp_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  wire logic [fstlp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               switch_level_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    effect_on_o,
  output logic                                    feedback_on_o,
  output logic                                    effect_lamp_o,
  output logic                                    effect_changed_o,
  output logic                                    feedback_changed_o
);
  import fstlp_pkg::*;

  logic [DebounceLimitW-1:0] debounce_limit_q;
  logic [LongPressW-1:0]     long_press_q;

  logic                      s1_valid_q, s1_level_q;
  logic                      out_valid_q;
  res_t                      res_q, res_d;

  logic [DEBOUNCE_WIDTH-1:0] integ_q, integ_d;
  logic [HOLD_WIDTH-1:0]     hold_q, hold_d;
  flags_t                    flags_q, flags_d;

  logic                      advance, accept;

  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  fstlp_step #(
    .HOLD_WIDTH     (HOLD_WIDTH),
    .DEBOUNCE_WIDTH (DEBOUNCE_WIDTH)
  ) u_step (
    .switch_level_i     (s1_level_q),
    .debounce_limit_i   (debounce_limit_q),
    .long_press_ticks_i (long_press_q),
    .integ_i            (integ_q),
    .hold_i             (hold_q),
    .flags_i            (flags_q),
    .integ_o            (integ_d),
    .hold_o             (hold_d),
    .flags_o            (flags_d),
    .res_o              (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_limit_q <= DebounceLimitRst;
      long_press_q     <= LongPressRst;
      integ_q          <= '0;
      hold_q           <= '0;
      flags_q          <= '{effect: InitialEffectRst, feedback: 1'b0,
                            lamp: InitialEffectRst, was_released: 1'b1,
                            toggle_pending: 1'b0, turning_on: 1'b0};
    end else begin
      if (advance) begin
        integ_q <= integ_d;
        hold_q  <= hold_d;
      end
      // restore write loads effect and lamp directly
      if (cfg_we_i && (cfg_index_i == CFG_INITIAL_EFFECT)) begin
        flags_q.effect <= cfg_data_i[0];
        flags_q.lamp   <= cfg_data_i[0];
      end else if (advance) begin
        flags_q <= flags_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_data_i[DebounceLimitW-1:0];
          CFG_LONG_PRESS:     long_press_q     <= cfg_data_i[LongPressW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !advance);
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_level_q <= switch_level_i;
    if (advance) res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign effect_on_o        = res_q.effect_on;
  assign feedback_on_o      = res_q.feedback_on;
  assign effect_lamp_o      = res_q.effect_lamp;
  assign effect_changed_o   = res_q.effect_changed;
  assign feedback_changed_o = res_q.feedback_changed;

endmodule

`default_nettype wire

// ----- verif/tb_footswitch_toggle_long_press_unit.sv -----
module tb_footswitch_toggle_long_press_unit;
  import fstlp_pkg::*;

  class footswitch_scoreboard;
    logic [DebounceLimitW-1:0] debounce_lim;
    logic [LongPressW-1:0]     long_press;
    logic [DebounceLimitW-1:0] integ;
    logic [LongPressW-1:0]     hold_cnt;
    logic eff, fb, lamp, released, toggle_pend, turn_on;
    res_t        expected_ticks[$];
    int unsigned ticks_checked, effect_toggles, feedback_toggles, errors, reports;

    function new();
      debounce_lim = DebounceLimitRst;
      long_press   = LongPressRst;
      integ        = '0;
      hold_cnt     = '0;
      eff          = InitialEffectRst;
      lamp         = InitialEffectRst;
      fb           = 1'b0;
      released     = 1'b1;
      toggle_pend  = 1'b0;
      turn_on      = 1'b0;
      ticks_checked = 0; effect_toggles = 0; feedback_toggles = 0;
      errors = 0; reports = 0;
    endfunction

    function void apply_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DEBOUNCE_LIMIT: debounce_lim = data[DebounceLimitW-1:0];
        CFG_LONG_PRESS:     long_press = data[LongPressW-1:0];
        CFG_INITIAL_EFFECT: begin
          eff  = data[0];
          lamp = data[0];
        end
        default: ;
      endcase
    endfunction

    function res_t advance_tick(logic lvl);
      res_t r;
      logic eff_chg, fb_chg;
      eff_chg = 1'b0;
      fb_chg  = 1'b0;
      if (!lvl) begin
        if (integ != 0) integ--;
      end else if (integ < debounce_lim) begin
        integ++;
      end
      if (integ == 0) begin
        if (hold_cnt != '1) hold_cnt++;
        if (eff) begin
          if (released) toggle_pend = 1'b1;
          if (hold_cnt >= long_press && !fb && !turn_on) begin
            hold_cnt = long_press;
            lamp     = 1'b0;
            fb       = 1'b1;
            fb_chg   = 1'b1;
          end
        end else begin
          turn_on     = 1'b1;
          toggle_pend = 1'b0;
          eff         = 1'b1;
          lamp        = 1'b1;
          eff_chg     = 1'b1;
          fb          = 1'b0;
        end
        released = 1'b0;
      end else if (integ >= debounce_lim) begin
        if (toggle_pend && !fb && eff) begin
          eff     = 1'b0;
          eff_chg = 1'b1;
        end
        lamp = eff;
        if (fb) begin
          fb     = 1'b0;
          fb_chg = 1'b1;
        end
        turn_on     = 1'b0;
        toggle_pend = 1'b0;
        released    = 1'b1;
        hold_cnt    = '0;
        integ       = debounce_lim;
      end
      r.effect_on        = eff;
      r.feedback_on      = fb;
      r.effect_lamp      = lamp;
      r.effect_changed   = eff_chg;
      r.feedback_changed = fb_chg;
      return r;
    endfunction

    function void note_switch_sample(logic lvl);
      expected_ticks.push_back(advance_tick(lvl));
    endfunction

    function void report_field(string name, logic e, logic a);
      if (e !== a) begin
        errors++;
        if (reports < 40) begin
          reports++;
          $display("%0t: %s expected %b, got %b", $time, name, e, a);
        end
      end
    endfunction

    function void check_tick_result(res_t got);
      res_t exp;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (reports < 40) begin
          reports++;
          $display("%0t: result word with nothing expected, expected none, got %b",
                   $time, got);
        end
        return;
      end
      exp = expected_ticks.pop_front();
      ticks_checked++;
      if (got.effect_changed === 1'b1) effect_toggles++;
      if (got.feedback_changed === 1'b1) feedback_toggles++;
      report_field("effect_on", exp.effect_on, got.effect_on);
      report_field("feedback_on", exp.feedback_on, got.feedback_on);
      report_field("effect_lamp", exp.effect_lamp, got.effect_lamp);
      report_field("effect_changed", exp.effect_changed, got.effect_changed);
      report_field("feedback_changed", exp.feedback_changed, got.feedback_changed);
    endfunction

    function int unsigned pending();
      return expected_ticks.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 switch_level_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 effect_on_o;
  logic                 feedback_on_o;
  logic                 effect_lamp_o;
  logic                 effect_changed_o;
  logic                 feedback_changed_o;

  footswitch_toggle_long_press_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .switch_level_i     (switch_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .effect_on_o        (effect_on_o),
    .feedback_on_o      (feedback_on_o),
    .effect_lamp_o      (effect_lamp_o),
    .effect_changed_o   (effect_changed_o),
    .feedback_changed_o (feedback_changed_o)
  );

  footswitch_scoreboard sb;
  int unsigned src_idle_pct = 38;
  int unsigned snk_idle_pct = 38;
  int unsigned words_sent = 0;
  int unsigned n_settings = 0;
  int unsigned cur_limit = 16;
  int unsigned cur_press = 20000000;
  int unsigned hold_left = 0;
  int unsigned longest_hold = 0;
  bit          hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("footswitch_toggle_long_press_unit: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_switch_sample(switch_level_i);
      if (out_valid_o && !out_stall_i) begin
        got.effect_on        = effect_on_o;
        got.feedback_on      = feedback_on_o;
        got.effect_lamp      = effect_lamp_o;
        got.effect_changed   = effect_changed_o;
        got.feedback_changed = feedback_changed_o;
        sb.check_tick_result(got);
      end
    end
  end

  // result side: random stall, or a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req  = 1'b0;
      if (hold_left > longest_hold) longest_hold = hold_left;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic lvl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    switch_level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_level(logic lvl, int unsigned n);
    repeat (n) send_word(lvl);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.apply_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_settings(logic [CfgDataW-1:0] limit_word,
                                logic [CfgDataW-1:0] press_ticks, logic start_effect);
    cfg_write(CFG_DEBOUNCE_LIMIT, limit_word);
    cfg_write(CFG_LONG_PRESS, press_ticks);
    cfg_write(CFG_INITIAL_EFFECT, {{(CfgDataW-1){1'b0}}, start_effect});
    cfg_we_i  <= 1'b0;
    cur_limit = 32'(limit_word[DebounceLimitW-1:0]);
    cur_press = 32'(press_ticks);
    n_settings++;
  endtask

  function automatic int unsigned capped(int unsigned x);
    return (x > 40) ? 40 : x;
  endfunction

  // one press gesture: clean short or long press, contact bounce, or a cut-off press
  task automatic random_gesture();
    int unsigned kind, lim, lp;
    lim  = capped(cur_limit);
    lp   = capped(cur_press);
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) send_word(1'($urandom_range(1)));
    end else if (kind < 20) begin
      hold_level(1'b0, $urandom_range(0, lim));
      hold_level(1'b1, $urandom_range(0, lim));
    end else begin
      repeat ($urandom_range(0, 3)) send_word(1'($urandom_range(1)));
      if (kind < 55) hold_level(1'b0, lim + 1 + $urandom_range(0, lp / 2));
      else hold_level(1'b0, lim + lp + $urandom_range(0, 4));
      repeat ($urandom_range(0, 3)) send_word(1'($urandom_range(1)));
      hold_level(1'b1, lim + 1 + $urandom_range(0, 3));
    end
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] limit_word, logic [CfgDataW-1:0] press_ticks,
                           logic start_effect, int unsigned words, int unsigned src_idle,
                           int unsigned snk_idle, bit burst);
    int unsigned start;
    wait_idle();
    write_settings(limit_word, press_ticks, start_effect);
    src_idle_pct = src_idle;
    snk_idle_pct = snk_idle;
    if (burst) hold_req = 1'b1;
    start = words_sent;
    while (words_sent - start < words) random_gesture();
    stop_sending();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_DEBOUNCE_LIMIT;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    switch_level_i = 1'b1;
    out_stall_i    = 1'b0;
    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // held from reset with effect restored on: feedback engages
    write_settings(25'd2, 25'd3, 1'b1);
    hold_level(1'b0, 7);
    stop_sending();
    wait_idle();
    // restore effect off while feedback is on, then press: feedback drops silently
    cfg_write(CFG_INITIAL_EFFECT, '0);
    cfg_we_i <= 1'b0;
    hold_level(1'b0, 2);
    hold_level(1'b1, 3);
    hold_level(1'b0, 3);
    hold_level(1'b1, 3);
    stop_sending();
    wait_idle();
    // zero debounce limit: always reads as held
    write_settings(25'd0, 25'd3, 1'b0);
    hold_level(1'b1, 2);
    hold_level(1'b0, 1);
    stop_sending();

    run_phase(25'd2, 25'd6, 1'b0, 250, 38, 38, 1'b0);
    run_phase(25'd1, 25'd1, 1'b1, 200, 38, 38, 1'b0);
    run_phase(25'd0, 25'd4, 1'b0, 100, 38, 38, 1'b0);
    run_phase(25'h1_0003, 25'd12, 1'b1, 250, 0, 0, 1'b1);
    run_phase(25'd5, 25'd20, 1'b0, 250, 38, 38, 1'b0);
    run_phase(25'd65535, 25'h1FF_FFFF, 1'b1, 60, 38, 38, 1'b0);
    run_phase(25'd4, 25'd9, 1'b0, 200, 38, 38, 1'b0);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d switch words sent, %0d results checked over %0d register settings",
             words_sent, sb.ticks_checked, n_settings);
    $display("%0d effect changes, %0d feedback changes, receiver hold-off %0d cycles",
             sb.effect_toggles, sb.feedback_toggles, longest_hold);
    if (sb.errors == 0) begin
      $display("footswitch_toggle_long_press_unit: match");
    end else begin
      $display("footswitch_toggle_long_press_unit: mismatch");
    end
    $finish;
  end

endmodule
